### design/pfd_pkg.sv
// Shared types, codes, mask tables and helpers for the page framebuffer.
// No dependencies; used by the RAM-based drawing engine and its checker.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  // Default geometry handed to the top level parameters.
  localparam int PANEL_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF   = 8;
  localparam int FRAME_BYTES_DEF = 1024;

  // The dirty bound tables always hold eight pages.
  localparam int DIRTY_PAGES = 8;

  // Dirty bound values that mean no dirty column.
  localparam logic [7:0] NO_DIRTY_LEFT  = 8'hFF;
  localparam logic [6:0] NO_DIRTY_RIGHT = 7'h00;

  // Request modes.
  typedef enum logic [2:0] {
    MODE_PIXEL       = 3'd0,
    MODE_HRUN        = 3'd1,
    MODE_VRUN        = 3'd2,
    MODE_READ        = 3'd3,
    MODE_CLEAR_DIRTY = 3'd4,
    MODE_CLEAR_FRAME = 3'd5
  } mode_t;

  // Colour codes.
  localparam logic [1:0] COLOUR_BLACK  = 2'd0;
  localparam logic [1:0] COLOUR_WHITE  = 2'd1;
  localparam logic [1:0] COLOUR_INVERT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_TALL_PANEL = 1'b0;
  localparam logic REG_TRACKING   = 1'b1;

  // Entry k has the top k bits set.
  localparam logic [0:7][7:0] HIGH_BITS =
    {8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE};
  // Entry k has the low k bits set.
  localparam logic [0:7][7:0] LOW_BITS =
    {8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F};

  // Applies a colour to the masked bits of one byte; an unknown colour
  // leaves the byte as it is.
  function automatic logic [7:0] apply_colour(input logic [7:0] data,
                                               input logic [7:0] mask,
                                               input logic [1:0] colour);
    logic [7:0] result;
    case (colour)
      COLOUR_BLACK:  result = data & ~mask;
      COLOUR_WHITE:  result = data | mask;
      COLOUR_INVERT: result = data ^ mask;
      default:       result = data;
    endcase
    return result;
  endfunction

endpackage

`default_nettype wire

### design/pfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/page_framebuffer_draw_dirty.sv
// Page-packed monochrome framebuffer with per-page dirty column bounds.
// Depends on pfd_pkg and on pfd_ram for the frame store.
//
//   Channel   Signals                                         Direction
//   request   start, busy, mode, x_pos, y_pos, run_length,    in, busy out
//             colour
//   result    done, pixel_byte, page_dirty_left,              out
//             page_dirty_right, accepted
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data       in, ready out
//
// A request passes through setup, a walk over the frame bytes it touches
// and a result state before the next is accepted. It touches 1 byte for a
// pixel or a read, up to PANEL_WIDTH for a horizontal run, up to 8 for a
// vertical run, pages * PANEL_WIDTH for a frame clear. Clear-dirty and
// rejected requests skip the walk. The walk is paced by the frame store's
// single read and write port: one byte read-modify-write per cycle,
// pipelined. After reset the block sweeps eight pages of the frame store
// to zero with busy high; configuration writes are taken throughout.
// done is high for one cycle per request; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_draw_dirty #(
  parameter int PANEL_WIDTH = pfd_pkg::PANEL_WIDTH_DEF,
  parameter int MAX_PAGES   = pfd_pkg::MAX_PAGES_DEF,
  parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Request channel.
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] x_pos,
  input  wire logic [7:0] y_pos,
  input  wire logic [7:0] run_length,
  input  wire logic [1:0] colour,
  // Result channel.
  output logic            done,
  output logic [7:0]      pixel_byte,
  output logic [7:0]      page_dirty_left,
  output logic [6:0]      page_dirty_right,
  output logic            accepted,
  // Configuration channel.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int IDX_W  = $clog2(pfd_pkg::DIRTY_PAGES * PANEL_WIDTH);
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam logic [3:0] PAGES_TALL  = 4'((MAX_PAGES < 8) ? MAX_PAGES : 8);
  localparam logic [3:0] PAGES_SHORT = 4'((MAX_PAGES < 4) ? MAX_PAGES : 4);
  localparam logic signed [9:0] PW_S = 10'(PANEL_WIDTH);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(PANEL_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic tall_panel;
  logic partial_tracking;

  // Dirty column bounds, one pair per page.
  logic [7:0] dirty_low_col  [pfd_pkg::DIRTY_PAGES];
  logic [6:0] dirty_high_col [pfd_pkg::DIRTY_PAGES];

  // Captured request.
  logic [2:0] req_mode;
  logic [7:0] req_x;
  logic [7:0] req_y;
  logic [7:0] req_len;
  logic [1:0] req_colour;

  // Job description: a rectangle of columns and pages plus bit masks.
  logic [COL_W-1:0] job_c0, job_c1;
  logic [2:0]       job_p0, job_p1;
  logic [2:0]       job_fb, job_lb;
  logic [1:0]       job_colour;
  logic             job_write, job_read, job_ok, job_mark, job_init;

  // Walk position.
  logic [COL_W-1:0] cur_col;
  logic [2:0]       cur_page;
  logic             walk_first;

  // Write-back stage.
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_mask;
  logic [7:0]        rd_data;

  logic [3:0] pages_act;
  logic [6:0] height;
  logic       cfg_fire;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign pages_act = tall_panel ? PAGES_TALL : PAGES_SHORT;
  assign height    = {pages_act[3:0], 3'b000};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tall_panel       <= 1'b1;
      partial_tracking <= 1'b1;
    end else if (cfg_fire) begin
      case (cfg_index)
        pfd_pkg::REG_TALL_PANEL: tall_panel       <= cfg_data;
        pfd_pkg::REG_TRACKING:   partial_tracking <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode: clipping and the rectangle of bytes to visit.
  logic signed [9:0] xs, ys, lens, xe, ye, ye_c, hgt;
  logic              x_on, y_on;
  logic [COL_W-1:0]  s_c0, s_c1;
  logic [2:0]        s_p0, s_p1, s_fb, s_lb;
  logic [1:0]        s_colour;
  logic              s_ok, s_walk, s_write, s_read, s_mark;

  always_comb begin
    xs   = {{2{req_x[7]}}, req_x};
    ys   = {{2{req_y[7]}}, req_y};
    lens = {2'b00, req_len};
    xe   = xs + lens - 10'sd1;
    ye   = ys + lens - 10'sd1;
    hgt  = {3'b000, height};
    ye_c = (ye > hgt - 10'sd1) ? (hgt - 10'sd1) : ye;
    x_on = !xs[9] && (xs < PW_S);
    y_on = !ys[9] && (ys < hgt);

    s_c0     = xs[COL_W-1:0];
    s_c1     = xs[COL_W-1:0];
    s_p0     = ys[5:3];
    s_p1     = ys[5:3];
    s_fb     = ys[2:0];
    s_lb     = ys[2:0];
    s_colour = req_colour;
    s_ok     = 1'b0;
    s_walk   = 1'b0;
    s_write  = 1'b0;
    s_read   = 1'b0;
    s_mark   = 1'b0;

    case (req_mode)
      pfd_pkg::MODE_PIXEL: begin
        s_ok    = x_on && y_on;
        s_walk  = s_ok;
        s_write = 1'b1;
        s_mark  = 1'b1;
      end
      pfd_pkg::MODE_HRUN: begin
        s_ok    = (req_len != 8'd0) && (xs < PW_S) && !xe[9] && y_on;
        s_walk  = s_ok;
        s_write = 1'b1;
        s_mark  = 1'b1;
        s_c0    = xs[9] ? '0 : xs[COL_W-1:0];
        s_c1    = (xe > PW_S - 10'sd1) ? LAST_COL : xe[COL_W-1:0];
      end
      pfd_pkg::MODE_VRUN: begin
        s_ok    = (req_len != 8'd0) && x_on && y_on;
        s_walk  = s_ok;
        s_write = 1'b1;
        s_mark  = 1'b1;
        s_p1    = ye_c[5:3];
        s_lb    = ye_c[2:0];
      end
      pfd_pkg::MODE_READ: begin
        s_ok   = x_on && y_on;
        s_walk = s_ok;
        s_read = 1'b1;
      end
      pfd_pkg::MODE_CLEAR_DIRTY: begin
        s_ok = partial_tracking;
      end
      pfd_pkg::MODE_CLEAR_FRAME: begin
        s_ok     = 1'b1;
        s_walk   = 1'b1;
        s_write  = 1'b1;
        s_mark   = 1'b1;
        s_c0     = '0;
        s_c1     = LAST_COL;
        s_p0     = 3'd0;
        s_p1     = 3'(pages_act - 4'd1);
        s_fb     = 3'd0;
        s_lb     = 3'd7;
        s_colour = pfd_pkg::COLOUR_BLACK;
      end
      default: ;
    endcase
  end

  // Byte index, range check and bit mask of the current walk step.
  logic [IDX_W-1:0] step_idx;
  logic             step_in_range;
  logic [7:0]       step_mask;
  logic             walk_last;

  always_comb begin
    step_idx      = IDX_W'(cur_page) * IDX_W'(PANEL_WIDTH) + IDX_W'(cur_col);
    step_in_range = ({1'b0, step_idx} < (IDX_W + 1)'(FRAME_BYTES));
    step_mask     = ((cur_page == job_p0) ? ~pfd_pkg::LOW_BITS[job_fb] : 8'hFF) &
                    ((cur_page == job_p1) ? ~pfd_pkg::HIGH_BITS[3'd7 - job_lb]
                                          : 8'hFF);
    walk_last     = (cur_col == job_c1) && (cur_page == job_p1);
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_mode   <= mode;
      req_x      <= x_pos;
      req_y      <= y_pos;
      req_len    <= run_length;
      req_colour <= colour;
    end
  end

  // Sequencer: setup, byte walk, result. Reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WALK;
      job_c0     <= '0;
      job_c1     <= LAST_COL;
      job_p0     <= 3'd0;
      job_p1     <= 3'(pfd_pkg::DIRTY_PAGES - 1);
      job_fb     <= 3'd0;
      job_lb     <= 3'd7;
      job_colour <= pfd_pkg::COLOUR_BLACK;
      job_write  <= 1'b1;
      job_read   <= 1'b0;
      job_ok     <= 1'b0;
      job_mark   <= 1'b0;
      job_init   <= 1'b1;
      cur_col    <= '0;
      cur_page   <= 3'd0;
      walk_first <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          job_c0     <= s_c0;
          job_c1     <= s_c1;
          job_p0     <= s_p0;
          job_p1     <= s_p1;
          job_fb     <= s_fb;
          job_lb     <= s_lb;
          job_colour <= s_colour;
          job_write  <= s_write;
          job_read   <= s_read;
          job_ok     <= s_ok;
          job_mark   <= s_mark;
          job_init   <= 1'b0;
          cur_col    <= s_c0;
          cur_page   <= s_p0;
          walk_first <= 1'b1;
          state      <= s_walk ? S_WALK : S_DONE;
        end
        S_WALK: begin
          walk_first <= 1'b0;
          if (walk_last) begin
            state <= S_DONE;
          end else if (cur_col == job_c1) begin
            cur_col  <= job_c0;
            cur_page <= cur_page + 3'd1;
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Write-back stage: the byte read in one walk cycle is modified and
  // written in the next. Addresses within a job never repeat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == S_WALK) && step_in_range;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ADDR_W'(step_idx);
    pend_mask <= step_mask;
  end

  pfd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_store (
    .clk   (clk),
    .we    (pend_valid && job_write),
    .waddr (pend_addr),
    .wdata (pfd_pkg::apply_colour(rd_data, pend_mask, job_colour)),
    .re    ((state == S_WALK) && step_in_range),
    .raddr (ADDR_W'(step_idx)),
    .rdata (rd_data)
  );

  // Dirty bounds: reset, clear on request or tracking enable, widen on draws.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < pfd_pkg::DIRTY_PAGES; p++) begin
        dirty_low_col[p]  <= pfd_pkg::NO_DIRTY_LEFT;
        dirty_high_col[p] <= pfd_pkg::NO_DIRTY_RIGHT;
      end
    end else if ((cfg_fire && (cfg_index == pfd_pkg::REG_TRACKING) && cfg_data) ||
                 ((state == S_SETUP) && (req_mode == pfd_pkg::MODE_CLEAR_DIRTY) &&
                  partial_tracking)) begin
      for (int p = 0; p < pfd_pkg::DIRTY_PAGES; p++) begin
        if (4'(p) < pages_act) begin
          dirty_low_col[p]  <= pfd_pkg::NO_DIRTY_LEFT;
          dirty_high_col[p] <= pfd_pkg::NO_DIRTY_RIGHT;
        end
      end
    end else if ((state == S_WALK) && walk_first && job_mark && partial_tracking) begin
      for (int p = 0; p < pfd_pkg::DIRTY_PAGES; p++) begin
        if ((3'(p) >= job_p0) && (3'(p) <= job_p1)) begin
          if (8'(job_c0) < dirty_low_col[p]) begin
            dirty_low_col[p] <= 8'(job_c0);
          end
          if (7'(job_c1) > dirty_high_col[p]) begin
            dirty_high_col[p] <= 7'(job_c1);
          end
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE) && !job_init;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      pixel_byte       <= (job_read && pend_valid) ? rd_data : 8'h00;
      page_dirty_left  <= (job_read && job_ok) ? dirty_low_col[job_p0]
                                               : pfd_pkg::NO_DIRTY_LEFT;
      page_dirty_right <= (job_read && job_ok) ? dirty_high_col[job_p0]
                                               : pfd_pkg::NO_DIRTY_RIGHT;
      accepted         <= job_ok;
    end
  end

endmodule

`default_nettype wire

### design/pfd_checker.sv
// Port-level checks for the page framebuffer, bound to the top level.
// Depends on pfd_pkg for the dirty bound constants.
`timescale 1ns / 1ps
`default_nettype none

module pfd_port_assertions (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] pixel_byte,
  input wire logic [7:0] page_dirty_left,
  input wire logic [6:0] page_dirty_right,
  input wire logic       accepted
);

  // Leaving reset starts the clearing sweep.
  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("block not busy after reset");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("block idle or done right after acceptance");

  // A result is delivered as the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result delivered while busy");

  // A rejected request reports the neutral result.
  a_reject_neutral: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> ((pixel_byte == 8'h00) &&
                             (page_dirty_left == pfd_pkg::NO_DIRTY_LEFT) &&
                             (page_dirty_right == pfd_pkg::NO_DIRTY_RIGHT)))
    else $error("rejected request with non-neutral result");

endmodule

bind page_framebuffer_draw_dirty pfd_port_assertions u_pfd_port_assertions (.*);

`default_nettype wire
